[rtl/mpksm_pkg.sv]
// ----------------------------------------------------------------------------
// mpksm_pkg: shared types, constants and pattern rom
// pattern lists, per-entry decode helpers and the flow record between cells
// ----------------------------------------------------------------------------
`default_nettype none

package mpksm_pkg;

    localparam int LIST_COUNT       = 5;
    localparam int ENTRIES_PER_LIST = 32;
    localparam int MAX_PATTERN_LEN  = 16;
    localparam int LIST_W           = 3;
    localparam int ENTRY_W          = 5;
    localparam int POS_W            = 4;
    localparam int LEN_W            = 5;
    localparam int TEXT_W           = 8 * 16;

    localparam logic [7:0]       WILD_CHAR = 8'h2a;
    localparam logic [LEN_W-1:0] EAT_DEPTH = LEN_W'(2);

    typedef enum logic [0:0] {
        REG_LIST_SELECT   = 1'b0,
        REG_DETECT_ENABLE = 1'b1
    } cfg_reg_t;

    // record handed from cell to cell
    typedef struct packed {
        logic                        vld;
        logic                        act;
        logic [LIST_W-1:0]           lst;
        logic [7:0]                  key;
        logic [ENTRIES_PER_LIST-1:0] hits;
        logic                        eat;
        logic                        have_arg;
        logic [7:0]                  a0;
        logic [7:0]                  a1;
    } flow_t;

    // pattern text, last character in the lowest byte, zero padded above
    function automatic logic [TEXT_W-1:0] pat_text(input logic [LIST_W-1:0] l,
                                                   input logic [ENTRY_W-1:0] e);
        logic [TEXT_W-1:0] t;
        t = '0;
        case (l)
            3'd0: begin
                case (e)
                    5'd0:  t = "idmus**";
                    5'd1:  t = "idbehold";
                    5'd2:  t = "idmypos";
                    5'd3:  t = "iddt";
                    5'd4:  t = "iddqd";
                    5'd5:  t = "idkfa";
                    5'd6:  t = "idfa";
                    5'd7:  t = "idspispopd";
                    5'd8:  t = "idclip";
                    5'd9:  t = "idbeholdv";
                    5'd10: t = "idbeholds";
                    5'd11: t = "idbeholdi";
                    5'd12: t = "idbeholdr";
                    5'd13: t = "idbeholda";
                    5'd14: t = "idbeholdl";
                    5'd15: t = "idchoppers";
                    5'd16: t = "idclev**";
                    default: t = '0;
                endcase
            end
            3'd1: begin
                case (e)
                    5'd0:  t = "noise";
                    5'd1:  t = "ticker";
                    5'd2:  t = "ravmap";
                    5'd3:  t = "quicken";
                    5'd4:  t = "kitty";
                    5'd5:  t = "rambo";
                    5'd6:  t = "shazam";
                    5'd7:  t = "ponce";
                    5'd8:  t = "skel";
                    5'd9:  t = "cockadoodledoo";
                    5'd10: t = "massacre";
                    5'd11: t = "engage**";
                    5'd12: t = "gimmea";
                    5'd13: t = "gimmeb";
                    5'd14: t = "gimmec";
                    5'd15: t = "gimmed";
                    5'd16: t = "gimmee";
                    5'd17: t = "gimmef";
                    5'd18: t = "gimmeg";
                    5'd19: t = "gimmeh";
                    5'd20: t = "gimmei";
                    5'd21: t = "gimmej";
                    5'd22: t = "gimmez";
                    5'd23: t = "idkfa";
                    5'd24: t = "iddqd";
                    default: t = '0;
                endcase
            end
            3'd2: begin
                case (e)
                    5'd0:  t = "satan";
                    5'd1:  t = "casper";
                    5'd2:  t = "nra";
                    5'd3:  t = "clubmed";
                    5'd4:  t = "locksmith";
                    5'd5:  t = "indiana";
                    5'd6:  t = "sherlock";
                    5'd7:  t = "visit**";
                    5'd8:  t = "deliverance";
                    5'd9:  t = "butcher";
                    5'd10: t = "conan";
                    5'd11: t = "where";
                    5'd12: t = "mapsco";
                    default: t = '0;
                endcase
            end
            3'd3: begin
                case (e)
                    5'd0:  t = "spin**";
                    5'd1:  t = "gps";
                    5'd2:  t = "topo";
                    5'd3:  t = "dots";
                    5'd4:  t = "omnipotent";
                    5'd5:  t = "gripper";
                    5'd6:  t = "jimmy";
                    5'd7:  t = "boomstix";
                    5'd8:  t = "elvis";
                    5'd9:  t = "stonecold";
                    5'd10: t = "pumpup";
                    5'd11: t = "pumpupb";
                    5'd12: t = "pumpupi";
                    5'd13: t = "pumpupm";
                    5'd14: t = "pumpuph";
                    5'd15: t = "pumpupp";
                    5'd16: t = "pumpups";
                    5'd17: t = "pumpupt";
                    5'd18: t = "rift**";
                    5'd19: t = "donnytrump";
                    5'd20: t = "scoot*";
                    5'd21: t = "lego";
                    default: t = '0;
                endcase
            end
            3'd4: begin
                case (e)
                    5'd0:  t = "kimhyers";
                    5'd1:  t = "sherrill";
                    5'd2:  t = "davidbrus";
                    5'd3:  t = "scottholman";
                    5'd4:  t = "mikekoenigs";
                    5'd5:  t = "charlesjacobi";
                    5'd6:  t = "andrewbenson";
                    5'd7:  t = "deanhyers";
                    5'd8:  t = "marybregi";
                    5'd9:  t = "allen";
                    5'd10: t = "digitalcafe";
                    5'd11: t = "joshuastorms";
                    5'd12: t = "joelkoenigs";
                    5'd13: t = "leesnyder**";
                    5'd14: t = "idmus**";
                    default: t = '0;
                endcase
            end
            default: t = '0;
        endcase
        return t;
    endfunction

    // pattern length, capped at the longest pattern handled
    function automatic logic [LEN_W-1:0] pat_len(input logic [TEXT_W-1:0] t);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int j = 0; j < 16; j++) begin
            if (t[j*8 +: 8] != 8'h00) n = n + LEN_W'(1);
        end
        if (n > LEN_W'(MAX_PATTERN_LEN)) n = LEN_W'(MAX_PATTERN_LEN);
        return n;
    endfunction

    // character at position p, valid for p below the length
    function automatic logic [7:0] pat_char(input logic [TEXT_W-1:0] t,
                                            input logic [LEN_W-1:0] n,
                                            input logic [POS_W-1:0] p);
        logic [LEN_W-1:0]  sh;
        logic [TEXT_W-1:0] v;
        sh = n - LEN_W'(1) - {1'b0, p};
        v  = t >> {sh[3:0], 3'b000};
        return v[7:0];
    endfunction

    // any wildcard ahead of position p
    function automatic logic pat_wild_before(input logic [TEXT_W-1:0] t,
                                             input logic [LEN_W-1:0] n,
                                             input logic [POS_W-1:0] p);
        logic any;
        any = 1'b0;
        for (int j = 0; j < 16; j++) begin
            if (t[j*8 +: 8] == WILD_CHAR && LEN_W'(j) < n &&
                (n - LEN_W'(1) - LEN_W'(j)) < {1'b0, p}) any = 1'b1;
        end
        return any;
    endfunction

    // wildcard slots in the pattern, saturated at two
    function automatic logic [1:0] pat_wild_count(input logic [TEXT_W-1:0] t,
                                                  input logic [LEN_W-1:0] n);
        logic [1:0] c;
        c = '0;
        for (int j = 0; j < 16; j++) begin
            if (t[j*8 +: 8] == WILD_CHAR && LEN_W'(j) < n && c != 2'd2) c = c + 2'd1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/multi_pattern_key_sequence_matcher.sv]
// ----------------------------------------------------------------------------
// multi_pattern_key_sequence_matcher: key sequence pattern detector
// a chain of entry cells checks every key against all patterns of a list
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake          payload
//  s_        in    s_tvalid/s_tready  tdata: key_code; tuser: key_down
//  m_        out   m_tvalid/m_tready  tdata: hit_mask, swallow, arg_first, arg_second
//  cfg_      in    cfg_wr_en          cfg_addr selects register, cfg_wdata value
//
//  one transfer in per cycle while the chain advances, one result per transfer, in order
//  each key passes through the register of every entry cell and then the output register
//  the rate is set by the cell chain, which moves the key one cell per cycle unless stalled
//  synchronous active-low reset clears all match positions and the chain
//  a held result stalls the chain only when the last cell also holds an item
//
`default_nettype none

module multi_pattern_key_sequence_matcher
    import mpksm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write port
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [2:0]  cfg_wdata,
    // key events
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] key_code
    input  wire logic        s_tuser,   // [0] key_down
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata    // [31:0] hit_mask, [32] swallow,
                                        // [40:33] arg_first, [48:41] arg_second
);

    logic [LIST_W-1:0] list_select_reg;
    logic              detect_enable_reg;

    flow_t             chain [ENTRIES_PER_LIST+1];
    flow_t             head_flow;
    logic              advance;

    logic              m_tvalid_reg;
    logic              m_tvalid_next;
    logic [48:0]       m_data_reg;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_select_reg   <= '0;
            detect_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_LIST_SELECT:   list_select_reg   <= cfg_wdata;
                REG_DETECT_ENABLE: detect_enable_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // the whole chain moves unless the last cell's item can not leave
    assign advance  = !(m_tvalid_reg && !m_tready && chain[ENTRIES_PER_LIST].vld);
    assign s_tready = advance;

    // head of the chain: the incoming transfer, empty result
    always_comb begin
        head_flow          = '0;
        head_flow.vld      = s_tvalid;
        head_flow.act      = detect_enable_reg && s_tuser &&
                             (list_select_reg < LIST_W'(LIST_COUNT));
        head_flow.lst      = list_select_reg;
        head_flow.key      = s_tdata;
    end

    assign chain[0] = head_flow;

    for (genvar g = 0; g < ENTRIES_PER_LIST; g++) begin : g_cell
        mpksm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .advance   (advance),
            .entry_idx (ENTRY_W'(g)),
            .flow_i    (chain[g]),
            .flow_o    (chain[g+1])
        );
    end

    // output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (advance && chain[ENTRIES_PER_LIST].vld) m_tvalid_next = 1'b1;
        else if (m_tready)                          m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else          m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (advance && chain[ENTRIES_PER_LIST].vld) begin
            m_data_reg <= {chain[ENTRIES_PER_LIST].a1, chain[ENTRIES_PER_LIST].a0,
                           chain[ENTRIES_PER_LIST].eat, chain[ENTRIES_PER_LIST].hits};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_data_reg};

    // ignored events leave the chain with an empty result
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[ENTRIES_PER_LIST].vld && !chain[ENTRIES_PER_LIST].act |->
        chain[ENTRIES_PER_LIST].hits == '0 && !chain[ENTRIES_PER_LIST].eat)
        else $error("ignored event produced a result");

    // arguments only come with a completion
    a_arg_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[ENTRIES_PER_LIST].vld && chain[ENTRIES_PER_LIST].have_arg |->
        chain[ENTRIES_PER_LIST].hits != '0)
        else $error("argument without completion");

    a_arg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[ENTRIES_PER_LIST].vld && !chain[ENTRIES_PER_LIST].have_arg |->
        chain[ENTRIES_PER_LIST].a0 == 8'h00 && chain[ENTRIES_PER_LIST].a1 == 8'h00)
        else $error("argument set without a capturing entry");

    // a stall always comes from a full output stage
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid_reg && chain[ENTRIES_PER_LIST].vld)
        else $error("chain stalled without a held result");

endmodule

`default_nettype wire

[rtl/mpksm_cell.sv]
// ----------------------------------------------------------------------------
// mpksm_cell: one pattern entry of every list
// holds the match positions and captured arguments of one entry slot
// ----------------------------------------------------------------------------
`default_nettype none

module mpksm_cell
    import mpksm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               advance,
    input  wire logic [ENTRY_W-1:0] entry_idx,
    input  wire flow_t              flow_i,
    output flow_t                   flow_o
);

    logic [POS_W-1:0] pos_reg  [LIST_COUNT];
    logic [7:0]       args_reg [LIST_COUNT][2];
    flow_t            flow_reg;

    logic [TEXT_W-1:0] text;
    logic [LEN_W-1:0]  len;
    logic              live;
    logic [POS_W-1:0]  pos;
    logic [7:0]        chr;
    logic              is_wild;
    logic [LEN_W-1:0]  np;
    logic              done;
    logic              slot;
    logic [1:0]        nwild;
    logic [7:0]        arg0_next;
    logic [7:0]        arg1_next;
    logic [POS_W-1:0]  pos_next;
    flow_t             flow_next;

    always_comb begin
        text    = pat_text(flow_i.lst, entry_idx);
        len     = pat_len(text);
        live    = flow_i.vld && flow_i.act && len != '0;
        pos     = pos_reg[flow_i.lst];
        chr     = pat_char(text, len, pos);
        is_wild = chr == WILD_CHAR;
        np      = (is_wild || chr == flow_i.key) ? {1'b0, pos} + LEN_W'(1) : '0;
        done    = np >= len;
        slot    = pat_wild_before(text, len, pos);
        nwild   = pat_wild_count(text, len);
        pos_next = done ? '0 : np[POS_W-1:0];

        arg0_next = args_reg[flow_i.lst][0];
        arg1_next = args_reg[flow_i.lst][1];
        if (is_wild) begin
            if (slot) arg1_next = flow_i.key;
            else      arg0_next = flow_i.key;
        end

        flow_next = flow_i;
        if (live) begin
            if (done) begin
                flow_next.hits[entry_idx] = 1'b1;
                if (!flow_i.have_arg && nwild != 2'd0) begin
                    flow_next.have_arg = 1'b1;
                    flow_next.a0       = arg0_next;
                    flow_next.a1       = (nwild == 2'd2) ? arg1_next : 8'h00;
                end
            end
            if (is_wild || (!done && np > EAT_DEPTH)) flow_next.eat = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_reg.vld <= 1'b0;
            for (int i = 0; i < LIST_COUNT; i++) pos_reg[i] <= '0;
        end else if (advance) begin
            flow_reg <= flow_next;
            if (live) pos_reg[flow_i.lst] <= pos_next;
        end
    end

    // captured arguments need no reset
    always_ff @(posedge aclk) begin
        if (advance && live) begin
            args_reg[flow_i.lst][0] <= arg0_next;
            args_reg[flow_i.lst][1] <= arg1_next;
        end
    end

    assign flow_o = flow_reg;

endmodule

`default_nettype wire
